/* design/bitmap_first_fit_allocator_unit_defines.svh */
// Assertion macros used by the allocator top file.
// Both macros sample on the rising edge of clk and are switched off during reset.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bffa_pkg.sv */
package bffa_pkg;

    // Width of one word of the free map and the shift that selects a word.
    localparam int WORD_BITS = 64;
    localparam int WORD_SH   = 6;

    // Request codes carried in the mode field.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Register index codes, taken from address bit 2.
    localparam logic REG_BASE_OFFSET = 1'b0;
    localparam logic REG_MAP_BLOCKS  = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_ALLOC_WR,
        ST_FREE_CHK,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_RESULT
    } bffa_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clr;
        logic       load;
        logic       scan_start;
        logic       scan;
        logic       free_chk;
        logic       free_mod;
        logic       wr;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_grant;
    } bffa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic hit;
        logic scan_done;
        logic out_range;
        logic out_busy;
    } bffa_stat_t;

endpackage

/* design/bitmap_first_fit_allocator_unit.sv */
// Channel   Direction  Handshake             Payload
// apb       in         psel/penable/pready   paddr, pwdata, pwrite, prdata
// request   in         in_valid/in_ready     mode, unit_id
// result    out        out_valid/out_ready   status, granted_id
//
// An allocate scans the map words from the lowest until one holds a free bit or
// the active part of the map is exhausted and the map is reported full;
// the scan reads one 64-bit word a cycle through the single read port of the
// free map. A free checks the id range, then reads and writes back its word;
// an out-of-range id skips both. After reset a clearing pass writes every map
// word once with in_ready low; register writes are taken during it.
// A result waits in the output register while the next item is accepted; the
// controller then holds the following result until that register is free.
`include "bitmap_first_fit_allocator_unit_defines.svh"

module bitmap_first_fit_allocator_unit #(
    parameter int BITS_PER_MAP_BLOCK = 4096,
    parameter int MAX_MAP_BLOCKS     = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] unit_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] granted_id
);

    localparam int TOTAL_BITS = BITS_PER_MAP_BLOCK * MAX_MAP_BLOCKS;
    localparam int LIM_W      = $clog2(TOTAL_BITS + 1);
    localparam int SAT_BLOCKS = (MAX_MAP_BLOCKS < 15) ? MAX_MAP_BLOCKS : 15;

    logic [31:0]          base_offset_reg;
    logic [3:0]           map_blocks_reg;
    logic [3:0]           blocks_sat;
    logic [LIM_W-1:0]     limit_reg;
    logic [LIM_W-1:0]     limit_next;
    logic                 cfg_wr;
    bffa_pkg::bffa_cmd_t  cmd;
    bffa_pkg::bffa_stat_t stat;

    // Register port: writes complete in the access phase, no wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg <= 32'd0;
            map_blocks_reg  <= 4'd8;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                bffa_pkg::REG_BASE_OFFSET: base_offset_reg <= pwdata;
                bffa_pkg::REG_MAP_BLOCKS:  map_blocks_reg  <= pwdata[3:0];
                default:                   base_offset_reg <= base_offset_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bffa_pkg::REG_BASE_OFFSET: prdata = base_offset_reg;
            bffa_pkg::REG_MAP_BLOCKS:  prdata = {28'd0, map_blocks_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Active map size in bits, block count saturated to the map capacity.
    assign blocks_sat = (map_blocks_reg > 4'(SAT_BLOCKS)) ? 4'(SAT_BLOCKS) : map_blocks_reg;
    assign limit_next = LIM_W'(32'(blocks_sat) * BITS_PER_MAP_BLOCK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    bffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    bffa_datapath #(
        .BITS_PER_MAP_BLOCK (BITS_PER_MAP_BLOCK),
        .MAX_MAP_BLOCKS     (MAX_MAP_BLOCKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .limit       (limit_reg),
        .base_offset (base_offset_reg),
        .unit_id     (unit_id),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .status      (status),
        .granted_id  (granted_id)
    );

    // Checks on the controller and result logic.
    `BFFA_ASSERT_SAME(a_no_accept_in_clear, cmd.clr, !in_ready, "item accepted while clearing")
    `BFFA_ASSERT_SAME(a_one_map_op, 1'b1, $onehot0({cmd.clr, cmd.wr, cmd.scan}), "map ops overlap")
    `BFFA_ASSERT_SAME(a_grant_only_ok, out_valid && (status != bffa_pkg::STATUS_OK),
                      granted_id == 32'd0, "granted id set on a failed request")
    `BFFA_ASSERT_NEXT(a_result_shown, cmd.res_load, out_valid, "loaded result not shown")

endmodule

/* design/bffa_datapath.sv */
module bffa_datapath #(
    parameter int BITS_PER_MAP_BLOCK = 4096,
    parameter int MAX_MAP_BLOCKS     = 8
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  bffa_pkg::bffa_cmd_t                                    cmd,
    output bffa_pkg::bffa_stat_t                                   stat,
    input  logic [$clog2(BITS_PER_MAP_BLOCK*MAX_MAP_BLOCKS+1)-1:0] limit,
    input  logic [31:0]                                            base_offset,
    input  logic [31:0]                                            unit_id,
    input  logic                                                   out_ready,
    output logic                                                   out_valid,
    output logic [1:0]                                             status,
    output logic [31:0]                                            granted_id
);

    localparam int TOTAL_BITS = BITS_PER_MAP_BLOCK * MAX_MAP_BLOCKS;
    localparam int WORDS      = (TOTAL_BITS + bffa_pkg::WORD_BITS - 1) / bffa_pkg::WORD_BITS;
    localparam int WORD_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W      = $clog2(WORDS + 1);
    localparam int LIM_W      = $clog2(TOTAL_BITS + 1);
    localparam int IDX_W      = WORD_W + bffa_pkg::WORD_SH;
    localparam int DW         = IDX_W + 1;

    // Free map storage, one 64-bit word per entry.
    logic [bffa_pkg::WORD_BITS-1:0] mem [WORDS];

    logic [31:0]                    unit_reg;
    logic [CNT_W-1:0]               addr_reg;
    logic                           rd_vld_reg;
    logic [WORD_W-1:0]              rd_word_reg;
    logic [bffa_pkg::WORD_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic [bffa_pkg::WORD_BITS-1:0] word_new_reg;
    logic                           out_valid_reg;
    logic [1:0]                     status_reg;
    logic [31:0]                    grant_reg;

    logic [LIM_W:0]                 lim_up;
    logic [CNT_W-1:0]               n_words;
    logic [DW-1:0]                  left;
    logic [bffa_pkg::WORD_BITS-1:0] mask;
    logic [bffa_pkg::WORD_BITS-1:0] avail;
    logic [bffa_pkg::WORD_BITS-1:0] low;
    logic [bffa_pkg::WORD_SH-1:0]   lsb_idx;
    logic                           hit;
    logic                           issue;
    logic [31:0]                    fidx;
    logic                           out_range;
    logic                           rd_en;
    logic [WORD_W-1:0]              rd_addr;
    logic                           out_busy;

    // Number of words that hold active units, rounded up.
    assign lim_up  = {1'b0, limit} + (LIM_W+1)'(bffa_pkg::WORD_BITS - 1);
    assign n_words = CNT_W'(lim_up >> bffa_pkg::WORD_SH);

    // Mask off the bits of the word under test that lie beyond the map end.
    assign left = DW'(limit) - DW'({rd_word_reg, {bffa_pkg::WORD_SH{1'b0}}});
    always_comb
    begin
        if (left < DW'(bffa_pkg::WORD_BITS))
        begin
            mask = ({{(bffa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << left[bffa_pkg::WORD_SH-1:0])
                   - {{(bffa_pkg::WORD_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            mask = '1;
        end
    end

    // Lowest free bit of the word under test, isolated and then encoded.
    assign avail = ~rd_data_reg & mask;
    assign low   = avail & (~avail + {{(bffa_pkg::WORD_BITS-1){1'b0}}, 1'b1});
    always_comb
    begin
        lsb_idx = '0;
        for (int i = 0; i < bffa_pkg::WORD_BITS; i++)
        begin
            if (low[i])
            begin
                lsb_idx = lsb_idx | bffa_pkg::WORD_SH'(i);
            end
        end
    end

    assign hit   = rd_vld_reg && (avail != '0);
    assign issue = cmd.scan && !hit && (addr_reg < n_words);

    // Free request: remove the base and check the index against the map end.
    assign fidx      = unit_reg - base_offset;
    assign out_range = fidx >= 32'(limit);

    assign rd_en   = issue || (cmd.free_chk && !out_range);
    assign rd_addr = cmd.free_chk ? fidx[IDX_W-1:bffa_pkg::WORD_SH] : addr_reg[WORD_W-1:0];

    assign out_busy = out_valid_reg && !out_ready;

    assign stat.clr_last  = addr_reg == CNT_W'(WORDS - 1);
    assign stat.hit       = hit;
    assign stat.scan_done = !rd_vld_reg && (addr_reg >= n_words);
    assign stat.out_range = out_range;
    assign stat.out_busy  = out_busy;

    // Scan and clear address counter, and read pipeline valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                addr_reg   <= '0;
                rd_vld_reg <= 1'b0;
            end
            else
            begin
                if (cmd.clr || issue)
                begin
                    addr_reg <= addr_reg + CNT_W'(1);
                end
                rd_vld_reg <= issue;
            end
        end
    end

    // Memory write port: clearing pass or write back of a modified word.
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            mem[addr_reg[WORD_W-1:0]] <= '0;
        end
        else if (cmd.wr)
        begin
            mem[idx_reg[IDX_W-1:bffa_pkg::WORD_SH]] <= word_new_reg;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (issue)
        begin
            rd_word_reg <= addr_reg[WORD_W-1:0];
        end
    end

    // Item capture, target index and the modified word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            unit_reg <= unit_id;
        end
        if (cmd.scan && hit)
        begin
            idx_reg      <= {rd_word_reg, lsb_idx};
            word_new_reg <= rd_data_reg | low;
        end
        else if (cmd.free_chk)
        begin
            idx_reg <= fidx[IDX_W-1:0];
        end
        else if (cmd.free_mod)
        begin
            word_new_reg <= rd_data_reg
                & ~({{(bffa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << idx_reg[bffa_pkg::WORD_SH-1:0]);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            grant_reg  <= cmd.res_grant ? (32'(idx_reg) + base_offset) : 32'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign granted_id = grant_reg;

endmodule

/* design/bffa_ctrl.sv */
module bffa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  bffa_pkg::bffa_stat_t stat,
    output bffa_pkg::bffa_cmd_t  cmd
);

    bffa_pkg::bffa_state_t state_reg;
    bffa_pkg::bffa_state_t state_next;
    logic [1:0]            res_status_reg;
    logic [1:0]            res_status_next;
    logic                  res_grant_reg;
    logic                  res_grant_next;

    // State and pending result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bffa_pkg::ST_CLEAR;
            res_status_reg <= bffa_pkg::STATUS_OK;
            res_grant_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_grant_reg  <= res_grant_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.res_status  = res_status_reg;
        cmd.res_grant   = res_grant_reg;

        unique case (state_reg)
            bffa_pkg::ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = bffa_pkg::ST_IDLE;
                end
            end
            bffa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = (mode == bffa_pkg::MODE_FREE) ? bffa_pkg::ST_FREE_CHK
                                                                   : bffa_pkg::ST_ALLOC;
                end
            end
            bffa_pkg::ST_ALLOC:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    state_next = bffa_pkg::ST_ALLOC_WR;
                end
                else if (stat.scan_done)
                begin
                    res_status_next = bffa_pkg::STATUS_FULL;
                    res_grant_next  = 1'b0;
                    state_next      = bffa_pkg::ST_RESULT;
                end
            end
            bffa_pkg::ST_ALLOC_WR:
            begin
                cmd.wr          = 1'b1;
                res_status_next = bffa_pkg::STATUS_OK;
                res_grant_next  = 1'b1;
                state_next      = bffa_pkg::ST_RESULT;
            end
            bffa_pkg::ST_FREE_CHK:
            begin
                cmd.free_chk = 1'b1;
                if (stat.out_range)
                begin
                    res_status_next = bffa_pkg::STATUS_RANGE;
                    res_grant_next  = 1'b0;
                    state_next      = bffa_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = bffa_pkg::ST_FREE_RD;
                end
            end
            bffa_pkg::ST_FREE_RD:
            begin
                cmd.free_mod = 1'b1;
                state_next   = bffa_pkg::ST_FREE_WR;
            end
            bffa_pkg::ST_FREE_WR:
            begin
                cmd.wr          = 1'b1;
                res_status_next = bffa_pkg::STATUS_OK;
                res_grant_next  = 1'b0;
                state_next      = bffa_pkg::ST_RESULT;
            end
            bffa_pkg::ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = bffa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bffa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
